FILE: rtl/core/cwt_pkg.sv
// Package for the config write tracker: command and response codes,
// store geometry and register offsets. No dependencies.
`timescale 1ns / 1ps

package cwt_pkg;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2,
    CmdBad   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RespOk      = 2'd0,
    RespAddrErr = 2'd1,
    RespCmdErr  = 2'd2
  } resp_e;

  localparam int unsigned StoreBytes = 65536;
  localparam int unsigned Lanes      = 4;
  localparam int unsigned StoreRows  = (StoreBytes + Lanes - 1) / Lanes;
  localparam int unsigned RowW       = $clog2(StoreRows);

  localparam logic [4:0]  HdrCfgWrite = 5'h04;
  localparam logic [31:0] OfsControl  = 32'd0;
  localparam logic [31:0] OfsModified = 32'd4;
  localparam logic [31:0] OfsBusDev   = 32'd8;
  localparam logic [2:0]  DevTypeRoot = 3'd4;
  localparam logic [2:0]  MaxCount    = 3'd4;

endpackage

FILE: rtl/core/config_write_tracker_regs.sv
// Config write tracker: modified-dword mask, write-1-to-clear queue and a
// byte store in four byte-lane memories. Depends on cwt_pkg.
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o   | mode, tick fields, bus access
// out     | output    | out_valid_o / out_ready_i | read data, response, state
//
// One word per cycle while input ready is high; a result passes the lane
// memory read, then the two-entry result buffer, on its way to the output.
// After reset a clearing pass zeroes all StoreRows rows (16384 at 64 KiB) of
// the store, one row of four bytes per cycle; no word is taken meanwhile.
// Words in flight are limited to the result buffer depth; a stalled output
// holds input ready low once two results are outstanding.

module config_write_tracker_regs
  import cwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic        core_reset_n_i,
  input  logic        cii_valid_i,
  input  logic [4:0]  cii_type_i,
  input  logic [11:0] cii_addr_i,
  input  logic [31:0] bus_offset_i,
  input  logic [2:0]  byte_count_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [1:0]  response_o,
  output logic        config_interrupt_o,
  output logic        root_port_mode_o,
  output logic [7:0]  bus_number_o,
  output logic [7:0]  device_number_o,
  output logic [31:0] modified_mask_o
);

  typedef struct packed {
    logic       rd_en;
    logic [2:0] cnt;
    logic [1:0] lo;
    resp_e      resp;
    logic       irq;
    logic       rp;
    logic [7:0] bus;
    logic [7:0] dev;
    logic [31:0] mask;
  } s1_t;

  typedef struct packed {
    logic [31:0] rdata;
    resp_e       resp;
    logic        irq;
    logic        rp;
    logic [7:0]  bus;
    logic [7:0]  dev;
    logic [31:0] mask;
  } res_t;

  // control state
  logic [31:0] mask_q, mask_d;
  logic [31:0] pend_q, pend_d;
  logic        irq_q, irq_d;
  logic        rp_q, rp_d;
  logic [7:0]  bus_q, bus_d;
  logic [7:0]  dev_q, dev_d;
  logic            clr_active_q;
  logic [RowW-1:0] clr_row_q;

  // pipeline and result buffer
  logic       s1_valid_q;
  s1_t        s1_q, s1_d;
  res_t       ent_q [2];
  res_t       res_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] occ_q;

  // input decode
  cmd_e        cmd;
  logic        accept, pop, push;
  logic [2:0]  cnt;
  logic [32:0] end_sum;
  logic        in_range;
  logic [1:0]  lo;
  logic [RowW-1:0] row0;
  logic [31:0] setbit;
  logic        is_tick, is_wr, tick_run;
  logic [2:0]  inflight;

  // lane memory ports
  logic            lane_we    [Lanes];
  logic [RowW-1:0] lane_waddr [Lanes];
  logic [7:0]      lane_wdata [Lanes];
  logic [RowW-1:0] lane_raddr [Lanes];
  logic [7:0]      lane_rdata_q [Lanes];

  assign cmd      = cmd_e'(mode_i);
  assign pop      = out_valid_o && out_ready_i;
  assign push     = s1_valid_q;
  assign inflight = {2'b0, s1_valid_q} + {1'b0, occ_q};
  assign in_ready_o = !clr_active_q && (inflight < (3'd2 + {2'b0, pop}));
  assign accept   = in_valid_i && in_ready_o;

  assign cnt      = (byte_count_i > MaxCount) ? MaxCount : byte_count_i;
  assign end_sum  = {1'b0, bus_offset_i} + {30'b0, cnt};
  assign in_range = end_sum <= 33'(StoreBytes);
  assign lo       = bus_offset_i[1:0];
  assign row0     = bus_offset_i[RowW+1:2];
  assign is_tick  = accept && (cmd == CmdTick);
  assign tick_run = is_tick && core_reset_n_i;
  assign is_wr    = accept && (cmd == CmdWrite) && in_range;

  always_comb begin
    setbit = '0;
    if (cii_valid_i && (cii_type_i == HdrCfgWrite) && (cii_addr_i[11:7] == 5'd0)) begin
      setbit = 32'd1 << cii_addr_i[6:2];
    end
  end

  always_comb begin
    mask_d = mask_q;
    pend_d = pend_q;
    irq_d  = irq_q;
    rp_d   = rp_q;
    bus_d  = bus_q;
    dev_d  = dev_q;
    if (is_tick) begin
      if (!core_reset_n_i) begin
        mask_d = '0;
        pend_d = '0;
        irq_d  = 1'b0;
      end else begin
        mask_d = (mask_q & ~pend_q) | setbit;
        pend_d = '0;
        irq_d  = (mask_d != 32'd0);
      end
    end else if (is_wr && (cnt == MaxCount)) begin
      if (bus_offset_i == OfsControl) begin
        rp_d = (write_data_i[2:0] == DevTypeRoot);
      end else if (bus_offset_i == OfsModified) begin
        pend_d = pend_q | write_data_i;
      end else if (bus_offset_i == OfsBusDev) begin
        bus_d = write_data_i[15:8];
        dev_d = write_data_i[7:0];
      end
    end
  end

  always_comb begin
    s1_d.rd_en = (cmd == CmdRead) && in_range;
    s1_d.cnt   = cnt;
    s1_d.lo    = lo;
    case (cmd)
      CmdTick:  s1_d.resp = RespOk;
      CmdRead,
      CmdWrite: s1_d.resp = in_range ? RespOk : RespAddrErr;
      default:  s1_d.resp = RespCmdErr;
    endcase
    s1_d.irq  = irq_d;
    s1_d.rp   = rp_d;
    s1_d.bus  = bus_d;
    s1_d.dev  = dev_d;
    s1_d.mask = mask_d;
  end

  // byte i of the access sits in lane (lo + i), one row further on wrap
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [1:0]      idx;
    logic [RowW-1:0] row;
    logic [7:0]      lane_mem_q [StoreRows];

    assign idx = 2'(l) - lo;
    assign row = row0 + RowW'(2'(l) < lo);
    assign lane_raddr[l] = row;

    always_comb begin
      lane_we[l]    = 1'b0;
      lane_waddr[l] = row;
      lane_wdata[l] = 8'(write_data_i >> {idx, 3'b000});
      if (clr_active_q) begin
        lane_we[l]    = 1'b1;
        lane_waddr[l] = clr_row_q;
        lane_wdata[l] = '0;
      end else if (tick_run) begin
        lane_we[l]    = 1'b1;
        lane_waddr[l] = RowW'(OfsModified >> 2);
        lane_wdata[l] = mask_d[8*l +: 8];
      end else if (is_wr && ({1'b0, idx} < cnt)) begin
        lane_we[l] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (lane_we[l]) begin
        lane_mem_q[lane_waddr[l]] <= lane_wdata[l];
      end
      lane_rdata_q[l] <= lane_mem_q[lane_raddr[l]];
    end
  end

  always_comb begin
    logic [1:0] sel;
    res_d.rdata = '0;
    for (int i = 0; i < Lanes; i++) begin
      sel = s1_q.lo + 2'(i);
      if (s1_q.rd_en && (3'(i) < s1_q.cnt)) begin
        res_d.rdata[8*i +: 8] = lane_rdata_q[sel];
      end
    end
    res_d.resp = s1_q.resp;
    res_d.irq  = s1_q.irq;
    res_d.rp   = s1_q.rp;
    res_d.bus  = s1_q.bus;
    res_d.dev  = s1_q.dev;
    res_d.mask = s1_q.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      pend_q       <= '0;
      irq_q        <= 1'b0;
      rp_q         <= 1'b0;
      bus_q        <= '0;
      dev_q        <= '0;
      clr_active_q <= 1'b1;
      clr_row_q    <= '0;
      s1_valid_q   <= 1'b0;
      wr_ptr_q     <= 1'b0;
      rd_ptr_q     <= 1'b0;
      occ_q        <= '0;
    end else begin
      mask_q <= mask_d;
      pend_q <= pend_d;
      irq_q  <= irq_d;
      rp_q   <= rp_d;
      bus_q  <= bus_d;
      dev_q  <= dev_d;
      if (clr_active_q) begin
        clr_row_q <= clr_row_q + RowW'(1);
        if (clr_row_q == RowW'(StoreRows - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      s1_valid_q <= accept;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      occ_q <= occ_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (push) begin
      ent_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_valid_o        = (occ_q != 2'd0);
  assign read_data_o        = ent_q[rd_ptr_q].rdata;
  assign response_o         = ent_q[rd_ptr_q].resp;
  assign config_interrupt_o = ent_q[rd_ptr_q].irq;
  assign root_port_mode_o   = ent_q[rd_ptr_q].rp;
  assign bus_number_o       = ent_q[rd_ptr_q].bus;
  assign device_number_o    = ent_q[rd_ptr_q].dev;
  assign modified_mask_o    = ent_q[rd_ptr_q].mask;

  a_buf_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (occ_q != 2'd2))
    else $error("result buffer overflow");

  a_irq_tracks_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q == (mask_q != 32'd0))
    else $error("interrupt out of step with mask");

  a_core_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_tick && !core_reset_n_i) |=> ((mask_q == 32'd0) && (pend_q == 32'd0)))
    else $error("core reset tick left mask or pending clears");

  a_clear_pass_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_active_q) |-> ($past(clr_row_q) == RowW'(StoreRows - 1)))
    else $error("clearing pass ended early");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for config_write_tracker_regs: ticks, bus reads,
// bus writes and bad commands against an in-bench predictor of the mask, clear queue and store.
// Depends on cwt_pkg and the RTL of config_write_tracker_regs.
`timescale 1ns / 1ps

import cwt_pkg::*;

typedef struct packed {
  cmd_e        mode;
  logic        core_rst_n;
  logic        cii_valid;
  logic [4:0]  cii_type;
  logic [11:0] cii_addr;
  logic [31:0] offset;
  logic [2:0]  count;
  logic [31:0] wdata;
} tracker_word_t;

typedef struct packed {
  logic [31:0] rdata;
  resp_e       resp;
  logic        irq;
  logic        rp;
  logic [7:0]  bus_num;
  logic [7:0]  dev_num;
  logic [31:0] mask;
} tracker_result_t;

class tracker_scoreboard;
  bit [7:0]        store [StoreBytes];
  bit [31:0]       mask;
  bit [31:0]       clear_q;
  bit              irq;
  bit              rp;
  bit [7:0]        bus_num;
  bit [7:0]        dev_num;
  tracker_result_t results_q[$];
  int unsigned     errors;

  function int unsigned pending();
    return results_q.size();
  endfunction

  function void note_word(tracker_word_t w);
    tracker_result_t r;
    int unsigned     n;
    logic [32:0]     end_addr;
    logic [31:0]     setbit;
    r = '0;
    r.resp = RespOk;
    n = 32'((w.count > MaxCount) ? MaxCount : w.count);
    end_addr = {1'b0, w.offset} + 33'(n);
    case (w.mode)
      CmdTick: begin
        if (!w.core_rst_n) begin
          mask = '0;
          clear_q = '0;
          irq = 1'b0;
        end else begin
          setbit = '0;
          if (w.cii_valid && w.cii_type == HdrCfgWrite && w.cii_addr[11:7] == 5'd0) begin
            setbit = 32'd1 << w.cii_addr[6:2];
          end
          mask = (mask & ~clear_q) | setbit;
          clear_q = '0;
          irq = (mask != 32'd0);
          for (int b = 0; b < 4; b++) store[OfsModified + b] = mask[8*b +: 8];
        end
      end
      CmdRead, CmdWrite: begin
        if (end_addr > StoreBytes) begin
          r.resp = RespAddrErr;
        end else if (w.mode == CmdRead) begin
          for (int i = 0; i < n; i++) r.rdata[8*i +: 8] = store[w.offset + i];
        end else begin
          for (int i = 0; i < n; i++) store[w.offset + i] = w.wdata[8*i +: 8];
          if (n == MaxCount) begin
            if (w.offset == OfsControl) begin
              rp = (w.wdata[2:0] == DevTypeRoot);
            end else if (w.offset == OfsModified) begin
              clear_q |= w.wdata;
            end else if (w.offset == OfsBusDev) begin
              bus_num = w.wdata[15:8];
              dev_num = w.wdata[7:0];
            end
          end
        end
      end
      default: r.resp = RespCmdErr;
    endcase
    r.irq = irq;
    r.rp = rp;
    r.bus_num = bus_num;
    r.dev_num = dev_num;
    r.mask = mask;
    results_q.push_back(r);
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(tracker_result_t got);
    tracker_result_t want;
    if (results_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      return;
    end
    want = results_q.pop_front();
    check_field("read_data", want.rdata, got.rdata);
    check_field("response", 32'(want.resp), 32'(got.resp));
    check_field("config_interrupt", 32'(want.irq), 32'(got.irq));
    check_field("root_port_mode", 32'(want.rp), 32'(got.rp));
    check_field("bus_number", 32'(want.bus_num), 32'(got.bus_num));
    check_field("device_number", 32'(want.dev_num), 32'(got.dev_num));
    check_field("modified_mask", want.mask, got.mask);
  endfunction
endclass

module testbench;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i         = '0;
  logic        core_reset_n_i = 1'b0;
  logic        cii_valid_i    = 1'b0;
  logic [4:0]  cii_type_i     = '0;
  logic [11:0] cii_addr_i     = '0;
  logic [31:0] bus_offset_i   = '0;
  logic [2:0]  byte_count_i   = '0;
  logic [31:0] write_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] read_data_o;
  logic [1:0]  response_o;
  logic        config_interrupt_o;
  logic        root_port_mode_o;
  logic [7:0]  bus_number_o;
  logic [7:0]  device_number_o;
  logic [31:0] modified_mask_o;

  bit gaps_on = 1'b1;

  tracker_scoreboard board = new;

  config_write_tracker_regs u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic tracker_word_t tick_word(logic rst_n, logic valid, logic [4:0] hdr,
                                              logic [11:0] addr);
    tracker_word_t w;
    w = '0;
    w.mode = CmdTick;
    w.core_rst_n = rst_n;
    w.cii_valid = valid;
    w.cii_type = hdr;
    w.cii_addr = addr;
    return w;
  endfunction

  function automatic tracker_word_t bus_word(cmd_e cmd, logic [31:0] ofs, logic [2:0] cnt,
                                             logic [31:0] data);
    tracker_word_t w;
    w = '0;
    w.mode = cmd;
    w.offset = ofs;
    w.count = cnt;
    w.wdata = data;
    return w;
  endfunction

  function automatic tracker_word_t random_word();
    tracker_word_t w;
    int unsigned   pick;
    w.core_rst_n = ($urandom_range(9) != 0);
    w.cii_valid = 1'($urandom_range(1));
    w.cii_type = ($urandom_range(9) < 7) ? HdrCfgWrite : 5'($urandom);
    w.cii_addr = ($urandom_range(9) < 7) ? 12'($urandom_range(127)) : 12'($urandom);
    w.wdata = $urandom;
    w.count = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
    pick = $urandom_range(99);
    if (pick < 35) w.mode = CmdTick;
    else if (pick < 60) w.mode = CmdRead;
    else if (pick < 95) w.mode = CmdWrite;
    else w.mode = CmdBad;
    pick = $urandom_range(9);
    if (pick < 3) begin
      w.offset = (pick == 0) ? OfsControl : (pick == 1) ? OfsModified : OfsBusDev;
      w.count = MaxCount;
    end else if (pick < 6) begin
      w.offset = $urandom_range(31);
    end else if (pick < 8) begin
      w.offset = $urandom_range(StoreBytes + 3, StoreBytes - 8);
    end else if (pick < 9) begin
      w.offset = $urandom_range(StoreBytes - 1);
    end else begin
      w.offset = $urandom;
    end
    return w;
  endfunction

  task automatic send_word(input tracker_word_t w);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= w.mode;
    core_reset_n_i <= w.core_rst_n;
    cii_valid_i    <= w.cii_valid;
    cii_type_i     <= w.cii_type;
    cii_addr_i     <= w.cii_addr;
    bus_offset_i   <= w.offset;
    byte_count_i   <= w.count;
    write_data_i   <= w.wdata;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(w);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // result side: sample at the edge, then decide the next stall
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        board.check_result({read_data_o, resp_e'(response_o), config_interrupt_o,
                            root_port_mode_o, bus_number_o, device_number_o,
                            modified_mask_o});
      end
      out_ready_i <= !(gaps_on && $urandom_range(99) < 11);
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(bus_word(CmdRead, OfsControl, 3'd4, '0));
    send_word(tick_word(1'b0, 1'b1, HdrCfgWrite, 12'h000));
    send_word(tick_word(1'b1, 1'b1, HdrCfgWrite, 12'h000));
    send_word(tick_word(1'b1, 1'b1, HdrCfgWrite, 12'h07C));
    send_word(tick_word(1'b1, 1'b1, HdrCfgWrite, 12'h080));
    send_word(tick_word(1'b1, 1'b1, 5'h05, 12'h010));
    send_word(tick_word(1'b1, 1'b0, HdrCfgWrite, 12'h008));
    send_word(bus_word(CmdRead, OfsModified, 3'd4, '0));
    // queued clear of bit 31 lands on the next tick
    send_word(bus_word(CmdWrite, OfsModified, 3'd4, 32'h8000_0000));
    send_word(tick_word(1'b1, 1'b1, HdrCfgWrite, 12'h008));
    send_word(bus_word(CmdWrite, OfsControl, 3'd4, 32'h0000_0004));
    send_word(bus_word(CmdWrite, OfsControl, 3'd4, 32'hFFFF_FFFB));
    send_word(bus_word(CmdWrite, OfsControl, 3'd4, 32'hFFFF_FFFC));
    send_word(bus_word(CmdWrite, OfsBusDev, 3'd4, 32'h0000_A5C3));
    send_word(bus_word(CmdWrite, OfsBusDev, 3'd2, 32'hFFFF_FFFF));
    send_word(bus_word(CmdWrite, OfsBusDev, 3'd7, 32'hFFFF_FFFF));
    send_word(bus_word(CmdWrite, StoreBytes - 4, 3'd4, 32'hDEAD_BEEF));
    send_word(bus_word(CmdRead, StoreBytes - 4, 3'd7, '0));
    send_word(bus_word(CmdRead, StoreBytes - 3, 3'd4, '0));
    send_word(bus_word(CmdWrite, 32'hFFFF_FFFF, 3'd1, 32'h0000_00FF));
    send_word(bus_word(CmdRead, StoreBytes, 3'd0, '0));
    send_word(bus_word(CmdRead, StoreBytes + 1, 3'd0, '0));
    send_word(bus_word(CmdBad, OfsControl, 3'd4, 32'hFFFF_FFFF));
    send_word(bus_word(CmdWrite, OfsModified + 1, 3'd1, 32'h0000_005A));
    send_word(bus_word(CmdRead, OfsModified, 3'd4, '0));
    send_word(tick_word(1'b0, 1'b1, 5'h1F, 12'hFFF));
    send_word(bus_word(CmdRead, OfsModified, 3'd4, '0));
    send_word(tick_word(1'b1, 1'b1, 5'h1F, 12'hFFF));
    drain_results();

    for (int k = 0; k < 600; k++) begin
      gaps_on <= !(k >= 200 && k < 350);
      if (k == 420) drain_results();
      send_word(random_word());
    end
    drain_results();
    repeat (8) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: config_write_tracker_regs.f
rtl/core/cwt_pkg.sv
rtl/core/config_write_tracker_regs.sv
tb/sv/testbench.sv
